/* sv/jdm_pkg.sv */
package jdm_pkg;

  typedef enum logic [2:0] {
    MODE_STOP = 3'd0,
    MODE_FWD  = 3'd1,
    MODE_BACK = 3'd2,
    MODE_CCW  = 3'd3,
    MODE_CW   = 3'd4
  } motion_t;

  // lamp bits: bit0..3 drive port bits 2,3,5,6
  localparam logic [3:0] LAMP_P2  = 4'b0001;
  localparam logic [3:0] LAMP_P3  = 4'b0010;
  localparam logic [3:0] LAMP_P5  = 4'b0100;
  localparam logic [3:0] LAMP_P6  = 4'b1000;
  localparam logic [3:0] LAMP_OFF = 4'b0000;

  localparam logic [15:0] TURN_PAIR_LIMIT_RST = 16'd10;

  typedef struct packed {
    logic [31:0] wheel_a_capture;
    logic [31:0] wheel_b_capture;
    logic        btn_up;
    logic        btn_center;
    logic        btn_left;
    logic        btn_down;
    logic        btn_right;
  } jdm_in_t;

  typedef struct packed {
    logic [2:0]  motion_out;
    logic [3:0]  led_out;
    logic [31:0] wheel_a_width_out;
    logic [31:0] wheel_b_width_out;
    logic        wheel_a_capture_edge;
    logic        wheel_b_capture_edge;
  } jdm_out_t;

  // per-wheel status towards the result and the mode logic
  typedef struct packed {
    logic [31:0] width;
    logic        edge_sel;
    logic        turn_end;
  } jdm_wheel_t;

endpackage

/* sv/jdm_wheel.sv */
module jdm_wheel (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [31:0]         capture,
  input  logic [15:0]         pair_limit,
  input  logic                clear_edges,
  output jdm_pkg::jdm_wheel_t status
);
  import jdm_pkg::*;

  logic [31:0] prev_r, prev_nxt;
  logic [31:0] edges_r, edges_nxt;
  logic [31:0] width_r, width_nxt;
  logic        sel_r, sel_nxt;
  logic [31:0] edges_trk;
  logic [31:0] edges_inc;

  assign edges_inc = edges_r + 32'd1;

  always_comb begin
    prev_nxt  = prev_r;
    edges_trk = edges_r;
    width_nxt = width_r;
    sel_nxt   = sel_r;
    if (capture != prev_r) begin
      edges_trk = edges_inc;
      if (!edges_inc[0]) begin
        // even count: pulse width valid from the second pair on
        if (edges_inc > 32'd2) begin
          width_nxt = capture - prev_r;
        end
        sel_nxt = 1'b0;
      end else begin
        sel_nxt = 1'b1;
      end
      prev_nxt = capture;
    end
    edges_nxt = clear_edges ? '0 : edges_trk;
  end

  assign status.width    = width_nxt;
  assign status.edge_sel = sel_nxt;
  assign status.turn_end = edges_trk[31:1] > {15'd0, pair_limit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      edges_r <= '0;
      width_r <= '0;
      sel_r   <= 1'b0;
    end else if (step) begin
      prev_r  <= prev_nxt;
      edges_r <= edges_nxt;
      width_r <= width_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

/* sv/jdm_mode.sv */
module jdm_mode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  jdm_pkg::jdm_in_t    item,
  input  logic                cw_end,
  input  logic                ccw_end,
  output jdm_pkg::motion_t    motion,
  output logic [3:0]          led,
  output logic                clear_edges
);
  import jdm_pkg::*;

  motion_t    motion_r, motion_nxt;
  logic [3:0] led_r, led_nxt;
  logic       started_r, started_nxt;
  logic       rlamp_r, rlamp_nxt;
  logic       llamp_r, llamp_nxt;
  motion_t    m_turn;

  // turn end, then blink, then the buttons by priority
  always_comb begin
    m_turn      = motion_r;
    led_nxt     = led_r;
    rlamp_nxt   = rlamp_r;
    llamp_nxt   = llamp_r;
    started_nxt = started_r;
    clear_edges = 1'b0;
    if (cw_end && (m_turn == MODE_CW)) begin
      m_turn  = MODE_STOP;
      led_nxt = LAMP_OFF;
    end
    if (ccw_end && (m_turn == MODE_CCW)) begin
      m_turn  = MODE_STOP;
      led_nxt = LAMP_OFF;
    end
    if (m_turn == MODE_CW) begin
      led_nxt   = rlamp_r ? LAMP_OFF : (LAMP_P3 | LAMP_P6);
      rlamp_nxt = !rlamp_r;
    end
    if (m_turn == MODE_CCW) begin
      led_nxt   = llamp_r ? LAMP_OFF : (LAMP_P2 | LAMP_P5);
      llamp_nxt = !llamp_r;
    end
    motion_nxt = m_turn;

    if (item.btn_up) begin
      started_nxt = 1'b1;
      motion_nxt  = MODE_FWD;
      led_nxt     = LAMP_P2 | LAMP_P3;
    end else if (item.btn_center) begin
      started_nxt = 1'b1;
      motion_nxt  = MODE_STOP;
      led_nxt     = LAMP_OFF;
    end else if (item.btn_left) begin
      if (started_r) begin
        llamp_nxt   = 1'b1;
        motion_nxt  = MODE_CCW;
        led_nxt     = LAMP_P2 | LAMP_P5;
        clear_edges = 1'b1;
      end
    end else if (item.btn_down) begin
      if (started_r) begin
        motion_nxt = MODE_BACK;
        led_nxt    = LAMP_P5 | LAMP_P6;
      end
    end else if (item.btn_right) begin
      rlamp_nxt   = 1'b1;
      started_nxt = 1'b1;
      motion_nxt  = MODE_CW;
      led_nxt     = LAMP_P3 | LAMP_P6;
      clear_edges = 1'b1;
    end
  end

  assign motion = motion_nxt;
  assign led    = led_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_r  <= MODE_STOP;
      led_r     <= LAMP_OFF;
      started_r <= 1'b0;
      rlamp_r   <= 1'b0;
      llamp_r   <= 1'b0;
    end else if (step) begin
      motion_r  <= motion_nxt;
      led_r     <= led_nxt;
      started_r <= started_nxt;
      rlamp_r   <= rlamp_nxt;
      llamp_r   <= llamp_nxt;
    end
  end

endmodule

/* sv/joystick_drive_mode_with_turn_odometry.sv */
// Channel | Direction | Handshake            | Beat payload
// in_     | input     | in_valid / in_stall   | jdm_in_t  : two captures, five buttons
// out_    | output    | out_valid / out_stall | jdm_out_t : mode, lamps, widths, edges
// cfg_    | input     | cfg_we                | cfg_wdata : turn_pair_limit
//
// One beat in and one beat out per cycle while out_stall is low; each beat passes the
// input register, then the mode/odometry update into the result register.
// The input register refills while a finished result waits, so both sides
// run at full rate unless out_stall holds the result register.
// Synchronous active-low reset clears valid flags, wheel and mode state; turn_pair_limit resets to 10.
// in_stall rises only while both the input and the result register are held.
module joystick_drive_mode_with_turn_odometry (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jdm_pkg::jdm_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output jdm_pkg::jdm_out_t out_item,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  import jdm_pkg::*;

  // input register
  logic       in_vld_r;
  jdm_in_t    in_item_r;
  // result register
  logic       out_vld_r;
  jdm_out_t   out_item_r, out_item_nxt;
  // configuration
  logic [15:0] limit_r;

  logic       step;
  jdm_wheel_t wheel_a, wheel_b;
  motion_t    motion;
  logic [3:0] led;
  logic       clear_edges;

  // the held beat moves on when the result register is free or being drained
  assign step     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= TURN_PAIR_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_item;
    end
  end

  // wheel A ends clockwise turns, wheel B counterclockwise ones
  jdm_wheel u_wheel_a (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .capture     (in_item_r.wheel_a_capture),
    .pair_limit  (limit_r),
    .clear_edges (clear_edges),
    .status      (wheel_a)
  );

  jdm_wheel u_wheel_b (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .capture     (in_item_r.wheel_b_capture),
    .pair_limit  (limit_r),
    .clear_edges (clear_edges),
    .status      (wheel_b)
  );

  jdm_mode u_mode (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_item_r),
    .cw_end      (wheel_a.turn_end),
    .ccw_end     (wheel_b.turn_end),
    .motion      (motion),
    .led         (led),
    .clear_edges (clear_edges)
  );

  always_comb begin
    out_item_nxt.motion_out           = motion;
    out_item_nxt.led_out              = led;
    out_item_nxt.wheel_a_width_out    = wheel_a.width;
    out_item_nxt.wheel_b_width_out    = wheel_b.width;
    out_item_nxt.wheel_a_capture_edge = wheel_a.edge_sel;
    out_item_nxt.wheel_b_capture_edge = wheel_b.edge_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // in_stall only when a beat is held on both sides
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_valid))
    else $error("in_stall without a held beat");

  // every processed beat shows up as a result next cycle
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid)
    else $error("processed beat lost");

  // motion code stays in range
  a_motion_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.motion_out <= MODE_CW))
    else $error("motion code out of range");

  // forward always shows the forward lamp pair
  a_fwd_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.motion_out == MODE_FWD)) |->
      (out_item.led_out == (LAMP_P2 | LAMP_P3)))
    else $error("forward without forward lamps");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import jdm_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned DEAD_LIMIT   = 2000; // cycles with no beat on either side
  localparam int unsigned HOLD_AT_BEAT = 250;  // result beat that triggers the long hold-off
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_BEATS  = 172;

  // joystick buttons, {up, center, left, down, right}
  localparam logic [4:0] BTN_NONE   = 5'b00000;
  localparam logic [4:0] BTN_UP     = 5'b10000;
  localparam logic [4:0] BTN_CENTER = 5'b01000;
  localparam logic [4:0] BTN_LEFT   = 5'b00100;
  localparam logic [4:0] BTN_DOWN   = 5'b00010;
  localparam logic [4:0] BTN_RIGHT  = 5'b00001;
  localparam logic [4:0] BTN_ALL    = 5'b11111;

  localparam int WHEEL_A = 0;
  localparam int WHEEL_B = 1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  jdm_in_t     in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  jdm_out_t    out_item;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  joystick_drive_mode_with_turn_odometry DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Loop-pass beats waiting to go in, and the results they are due to give
  // ---------------------------------------------------------------------------
  jdm_in_t  stick_beats_q[$];
  jdm_out_t drive_results_due[$];
  int       mismatches = 0;
  bit       no_idle = 1'b0;        // final phase runs both sides flat out

  // running encoder timestamps for the stimulus
  logic [31:0] ts_a = '0;
  logic [31:0] ts_b = '0;

  // ---------------------------------------------------------------------------
  // Drive-mode predictor: own copy of the block's state and register
  // ---------------------------------------------------------------------------
  logic [15:0] turn_pairs_max = TURN_PAIR_LIMIT_RST;
  motion_t     drv_mode = MODE_STOP;
  logic        started = 1'b0;
  logic        cw_lit = 1'b0;
  logic        ccw_lit = 1'b0;
  logic [3:0]  lamps = LAMP_OFF;
  logic [31:0] odo_prev[2] = '{default: '0};
  logic [31:0] odo_edges[2] = '{default: '0};
  logic [31:0] odo_width[2] = '{default: '0};
  logic        odo_fall[2] = '{default: 1'b0};

  // a new timestamp counts one edge; every even count past two latches a width
  task automatic track_wheel(input int w, input logic [31:0] cap);
    if (cap != odo_prev[w]) begin
      odo_edges[w] = odo_edges[w] + 32'd1;
      if (!odo_edges[w][0]) begin
        if (odo_edges[w] > 32'd2) odo_width[w] = cap - odo_prev[w];
        odo_fall[w] = 1'b0;
      end else begin
        odo_fall[w] = 1'b1;
      end
      odo_prev[w] = cap;
    end
  endtask

  // a turn stops once its wheel has run more edge pairs than the limit
  task automatic end_turn(input int w, input motion_t turn);
    if ((odo_edges[w] >> 1) > {16'd0, turn_pairs_max} && drv_mode == turn) begin
      drv_mode = MODE_STOP;
      lamps    = LAMP_OFF;
    end
  endtask

  task automatic step_drive_model(input jdm_in_t b);
    jdm_out_t r;
    track_wheel(WHEEL_A, b.wheel_a_capture);
    end_turn(WHEEL_A, MODE_CW);
    track_wheel(WHEEL_B, b.wheel_b_capture);
    end_turn(WHEEL_B, MODE_CCW);

    // indicators blink once per pass while a turn is active
    if (drv_mode == MODE_CW) begin
      lamps  = cw_lit ? LAMP_OFF : (LAMP_P3 | LAMP_P6);
      cw_lit = !cw_lit;
    end
    if (drv_mode == MODE_CCW) begin
      lamps   = ccw_lit ? LAMP_OFF : (LAMP_P2 | LAMP_P5);
      ccw_lit = !ccw_lit;
    end

    // buttons by priority; left and down do nothing until first start
    if (b.btn_up) begin
      started  = 1'b1;
      drv_mode = MODE_FWD;
      lamps    = LAMP_P2 | LAMP_P3;
    end else if (b.btn_center) begin
      started  = 1'b1;
      drv_mode = MODE_STOP;
      lamps    = LAMP_OFF;
    end else if (b.btn_left) begin
      if (started) begin
        ccw_lit            = 1'b1;
        drv_mode           = MODE_CCW;
        lamps              = LAMP_P2 | LAMP_P5;
        odo_edges[WHEEL_A] = '0;
        odo_edges[WHEEL_B] = '0;
      end
    end else if (b.btn_down) begin
      if (started) begin
        drv_mode = MODE_BACK;
        lamps    = LAMP_P5 | LAMP_P6;
      end
    end else if (b.btn_right) begin
      cw_lit             = 1'b1;
      started            = 1'b1;
      drv_mode           = MODE_CW;
      lamps              = LAMP_P3 | LAMP_P6;
      odo_edges[WHEEL_A] = '0;
      odo_edges[WHEEL_B] = '0;
    end

    r.motion_out           = drv_mode;
    r.led_out              = lamps;
    r.wheel_a_width_out    = odo_width[WHEEL_A];
    r.wheel_b_width_out    = odo_width[WHEEL_B];
    r.wheel_a_capture_edge = odo_fall[WHEEL_A];
    r.wheel_b_capture_edge = odo_fall[WHEEL_B];
    drive_results_due.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers the oldest pending beat, idles in random bursts
  // ---------------------------------------------------------------------------
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    logic taken;
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        step_drive_model(in_item);
        void'(stick_beats_q.pop_front());
      end
      if (in_valid && !taken) begin
        offer = 1'b1;              // stalled beat holds as it is
      end else begin
        offer = 1'b0;
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 8) - 1;
        end else if (stick_beats_q.size() != 0) begin
          offer = 1'b1;
          in_item <= stick_beats_q[0];
        end
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted beat and stalls at random, once long
  // ---------------------------------------------------------------------------
  int unsigned out_gap = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    jdm_out_t want;
    logic     hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (drive_results_due.size() == 0) begin
          $error("result beat with nothing outstanding: %0h", out_item);
          mismatches++;
        end else begin
          want = drive_results_due.pop_front();
          check_field("motion_out", 32'(want.motion_out), 32'(out_item.motion_out));
          check_field("led_out", 32'(want.led_out), 32'(out_item.led_out));
          check_field("wheel_a_width_out", want.wheel_a_width_out,
                      out_item.wheel_a_width_out);
          check_field("wheel_b_width_out", want.wheel_b_width_out,
                      out_item.wheel_b_width_out);
          check_field("wheel_a_capture_edge", 32'(want.wheel_a_capture_edge),
                      32'(out_item.wheel_a_capture_edge));
          check_field("wheel_b_capture_edge", 32'(want.wheel_b_capture_edge),
                      32'(out_item.wheel_b_capture_edge));
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && !no_idle && results_seen >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      hold = 1'b0;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        hold = 1'b1;
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
        hold = 1'b1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 8) - 1;
        hold = 1'b1;
      end
      out_stall <= hold;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no beat moving on either channel
  // ---------------------------------------------------------------------------
  int unsigned dead_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        dead_cycles = 0;
      end else begin
        dead_cycles++;
      end
      if (dead_cycles >= DEAD_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_beat(input logic [4:0] btns, input logic [31:0] cap_a,
                            input logic [31:0] cap_b);
    jdm_in_t b;
    b.wheel_a_capture = cap_a;
    b.wheel_b_capture = cap_b;
    {b.btn_up, b.btn_center, b.btn_left, b.btn_down, b.btn_right} = btns;
    stick_beats_q.push_back(b);
    ts_a = cap_a;
    ts_b = cap_b;
  endtask

  // mostly steady encoder ticks with the odd button press; a little noise
  task automatic queue_random(input int n);
    logic [4:0]  btns;
    logic [31:0] cap_a;
    logic [31:0] cap_b;
    for (int i = 0; i < n; i++) begin
      cap_a = ts_a;
      cap_b = ts_b;
      if ($urandom_range(0, 99) < 80) cap_a = ts_a + $urandom_range(1, 50000);
      if ($urandom_range(0, 99) < 80) cap_b = ts_b + $urandom_range(1, 50000);
      if ($urandom_range(0, 99) < 3) cap_a = $urandom();
      if ($urandom_range(0, 99) < 3) cap_b = $urandom();
      btns = BTN_NONE;
      if ($urandom_range(0, 99) < 6) begin
        case ($urandom_range(0, 9))
          0, 1, 2: btns = BTN_RIGHT;
          3, 4, 5: btns = BTN_LEFT;
          6:       btns = BTN_UP;
          7:       btns = BTN_CENTER;
          8:       btns = BTN_DOWN;
          default: btns = 5'($urandom_range(0, 31));
        endcase
      end
      queue_beat(btns, cap_a, cap_b);
    end
  endtask

  // every pass gives one result, so idle means all results in plus latency
  task automatic drain_results();
    while (stick_beats_q.size() != 0 || drive_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_turn_limit(input logic [15:0] pairs);
    cfg_we         <= 1'b1;
    cfg_wdata      <= pairs;
    turn_pairs_max  = pairs;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] phase_limit;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: button priority and the before-start lock-out
    queue_beat(BTN_LEFT, 32'h0, 32'h0);                  // ignored, no edge
    queue_beat(BTN_DOWN, 32'h5, 32'hFFFF_FFFF);          // ignored, first edges
    queue_beat(BTN_NONE, 32'hFFFF_FFFF, 32'h0);          // another edge on each wheel, no width yet
    queue_beat(BTN_ALL, 32'h0, 32'hFFFF_FFFF);           // up wins
    queue_beat(BTN_CENTER | BTN_LEFT | BTN_DOWN | BTN_RIGHT,
               32'h8000_0000, 32'h7FFF_FFFF);            // center wins, widths latch
    queue_beat(BTN_LEFT | BTN_DOWN | BTN_RIGHT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_beat(BTN_NONE, 32'h8000_0000, 32'h7FFF_FFFF);  // ccw blink
    queue_beat(BTN_NONE, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_beat(BTN_DOWN | BTN_RIGHT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_beat(BTN_RIGHT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_beat(BTN_NONE, 32'h8000_0000, 32'h7FFF_FFFF);  // cw blink
    queue_beat(BTN_NONE, 32'h8000_0000, 32'h7FFF_FFFF);
    drain_results();

    // zero limit: a single edge pair ends a turn, only on its own wheel
    write_turn_limit(16'd0);
    queue_beat(BTN_RIGHT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_beat(BTN_NONE, 32'h8000_0010, 32'h7FFF_FFF0);  // B edge does not end cw
    queue_beat(BTN_NONE, 32'h8000_0030, 32'h7FFF_FFF0);  // A pair: cw stops
    queue_beat(BTN_LEFT, 32'h8000_0030, 32'h7FFF_FFF0);
    queue_beat(BTN_NONE, 32'h8000_0040, 32'h7FFF_FFF8);
    queue_beat(BTN_NONE, 32'h8000_0050, 32'h0000_0003);  // B pair: ccw stops
    queue_beat(BTN_UP, 32'h8000_0050, 32'h0000_0003);
    queue_beat(BTN_DOWN, 32'h8000_0050, 32'h0000_0003);
    drain_results();

    // random phases over a spread of limits, the last one without idling
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       phase_limit = 16'hFFFF;
        1:       phase_limit = 16'd1;
        2:       phase_limit = 16'd2;
        3:       phase_limit = 16'($urandom_range(0, 12));
        4:       phase_limit = 16'($urandom_range(0, 65535));
        default: phase_limit = 16'd4;
      endcase
      if (phase == 5) no_idle = 1'b1;
      write_turn_limit(phase_limit);
      queue_random(PHASE_BEATS);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
